FILE: rtl/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and constants for the Halton box sampler
// Coordinate format, axis codes, register map and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

  localparam int COORD_W   = 24;
  localparam int NUM_AXES  = 3;
  localparam int CFG_IDX_W = 3;

  localparam int DEF_INDEX_BITS    = 20;
  localparam int DEF_FRACTION_BITS = 24;
  localparam int DEF_BASE_X        = 2;
  localparam int DEF_BASE_Y        = 3;
  localparam int DEF_BASE_Z        = 5;

  typedef logic [NUM_AXES-1:0][COORD_W-1:0] coord_vec_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_X = 3'd0,
    CFG_MIN_Y = 3'd1,
    CFG_MIN_Z = 3'd2,
    CFG_MAX_X = 3'd3,
    CFG_MAX_Y = 3'd4,
    CFG_MAX_Z = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: rtl/halton_box_sampler.sv
// ----------------------------------------------------------------------------
// halton_box_sampler: 3-D Halton point scaled into a configured box
// The engine places the three axes one after another and hands the point to
// the output register once all are placed. The next index is taken in the
// cycle after the point leaves the engine, so no new index is accepted while
// one is in flight; the shared multiplier and the bit-serial division serve each axis.
// Sync active-low reset; box registers clear to zero, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module halton_box_sampler #(
  parameter int INDEX_BITS    = hbs_pkg::DEF_INDEX_BITS,
  parameter int FRACTION_BITS = hbs_pkg::DEF_FRACTION_BITS,
  parameter int BASE_X        = hbs_pkg::DEF_BASE_X,
  parameter int BASE_Y        = hbs_pkg::DEF_BASE_Y,
  parameter int BASE_Z        = hbs_pkg::DEF_BASE_Z
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [hbs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic signed [hbs_pkg::COORD_W-1:0]   cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [INDEX_BITS-1:0]                in_sample_index,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [hbs_pkg::COORD_W-1:0]        out_pos_x,
  output logic signed [hbs_pkg::COORD_W-1:0]        out_pos_y,
  output logic signed [hbs_pkg::COORD_W-1:0]        out_pos_z
);

  hbs_pkg::coord_vec_t box_min_r;
  hbs_pkg::coord_vec_t box_max_r;
  hbs_pkg::coord_vec_t out_pos_r;
  logic                out_valid_r;

  logic                eng_idle;
  logic                eng_res_valid;
  logic                eng_res_ready;
  hbs_pkg::coord_vec_t eng_res_pos;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_r <= '0;
      box_max_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (hbs_pkg::cfg_reg_t'(cfg_index))
        hbs_pkg::CFG_MIN_X: box_min_r[hbs_pkg::AXIS_X] <= cfg_data;
        hbs_pkg::CFG_MIN_Y: box_min_r[hbs_pkg::AXIS_Y] <= cfg_data;
        hbs_pkg::CFG_MIN_Z: box_min_r[hbs_pkg::AXIS_Z] <= cfg_data;
        hbs_pkg::CFG_MAX_X: box_max_r[hbs_pkg::AXIS_X] <= cfg_data;
        hbs_pkg::CFG_MAX_Y: box_max_r[hbs_pkg::AXIS_Y] <= cfg_data;
        hbs_pkg::CFG_MAX_Z: box_max_r[hbs_pkg::AXIS_Z] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hbs_engine #(
    .INDEX_BITS    (INDEX_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .BASE_X        (BASE_X),
    .BASE_Y        (BASE_Y),
    .BASE_Z        (BASE_Z)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && in_ready),
    .index     (in_sample_index),
    .idle      (eng_idle),
    .box_min   (box_min_r),
    .box_max   (box_max_r),
    .res_valid (eng_res_valid),
    .res_ready (eng_res_ready),
    .res_pos   (eng_res_pos)
  );

  assign in_ready      = eng_idle;
  assign eng_res_ready = !out_valid_r || out_ready;

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_res_valid && eng_res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid && eng_res_ready) begin
      out_pos_r <= eng_res_pos;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = out_pos_r[hbs_pkg::AXIS_X];
  assign out_pos_y = out_pos_r[hbs_pkg::AXIS_Y];
  assign out_pos_z = out_pos_r[hbs_pkg::AXIS_Z];

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("engine still ready after taking a beat");

  a_result_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    eng_res_valid |-> !in_ready)
    else $error("engine result pending while idle");

  a_out_from_engine: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(eng_res_valid))
    else $error("output beat without engine result");
`endif

endmodule

`default_nettype wire

FILE: rtl/hbs_mul.sv
// ----------------------------------------------------------------------------
// hbs_mul: shared unsigned multiplier with registered product
// Serves both the reciprocal digit split and the box scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_mul #(
  parameter int AW = 24,
  parameter int BW = 24
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic      [AW+BW-1:0] p
);

  logic [AW+BW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= (AW+BW)'(a) * (AW+BW)'(b);
  end

  assign p = prod_r;

endmodule

`default_nettype wire

FILE: rtl/hbs_engine.sv
// ----------------------------------------------------------------------------
// hbs_engine: sequencer for radical inverse and box placement
// Per axis: digit split by reciprocal multiply, restoring long division
// one bit per cycle, then scaling by the box span on the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_engine #(
  parameter int INDEX_BITS    = hbs_pkg::DEF_INDEX_BITS,
  parameter int FRACTION_BITS = hbs_pkg::DEF_FRACTION_BITS,
  parameter int BASE_X        = hbs_pkg::DEF_BASE_X,
  parameter int BASE_Y        = hbs_pkg::DEF_BASE_Y,
  parameter int BASE_Z        = hbs_pkg::DEF_BASE_Z
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [INDEX_BITS-1:0]  index,
  output logic                        idle,
  input  wire hbs_pkg::coord_vec_t    box_min,
  input  wire hbs_pkg::coord_vec_t    box_max,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output hbs_pkg::coord_vec_t         res_pos
);

  localparam int CW    = hbs_pkg::COORD_W;
  localparam int BMAX_XY = (BASE_X > BASE_Y) ? BASE_X : BASE_Y;
  localparam int BMAX  = (BMAX_XY > BASE_Z) ? BMAX_XY : BASE_Z;
  localparam int DW    = $clog2(BMAX);
  localparam int NUMW  = INDEX_BITS + DW;
  localparam int AW    = (INDEX_BITS > CW) ? INDEX_BITS : CW;
  localparam int BW    = (INDEX_BITS + 1 > FRACTION_BITS) ? INDEX_BITS + 1 : FRACTION_BITS;
  localparam int PW    = AW + BW;
  localparam int CNTW  = $clog2(FRACTION_BITS + 1);
  localparam int L_X   = $clog2(BASE_X);
  localparam int L_Y   = $clog2(BASE_Y);
  localparam int L_Z   = $clog2(BASE_Z);
  localparam int S_X   = INDEX_BITS + L_X;
  localparam int S_Y   = INDEX_BITS + L_Y;
  localparam int S_Z   = INDEX_BITS + L_Z;
  localparam logic [BW-1:0] M_X =
    BW'(((64'd1 << S_X) + 64'(BASE_X - 1)) / 64'(BASE_X));
  localparam logic [BW-1:0] M_Y =
    BW'(((64'd1 << S_Y) + 64'(BASE_Y - 1)) / 64'(BASE_Y));
  localparam logic [BW-1:0] M_Z =
    BW'(((64'd1 << S_Z) + 64'(BASE_Z - 1)) / 64'(BASE_Z));

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_MULQ,
    S_DIGIT,
    S_DIV,
    S_SCALE,
    S_FIN,
    S_DONE
  } state_t;

  state_t                 state_r;
  hbs_pkg::axis_t         axis_r;
  logic [INDEX_BITS-1:0]  idx_in_r;
  logic [INDEX_BITS-1:0]  idx_r;
  logic [NUMW-1:0]        num_r;
  logic [NUMW-1:0]        den_r;
  logic [NUMW-1:0]        rem_r;
  logic [FRACTION_BITS-1:0] frac_r;
  logic [CNTW-1:0]        cnt_r;
  logic [CW-1:0]          lo_r;
  logic                   neg_r;
  logic [CW-1:0]          spanmag_r;
  hbs_pkg::coord_vec_t    pos_r;

  logic [AW-1:0]          mul_a;
  logic [BW-1:0]          mul_b;
  logic [PW-1:0]          prod;

  logic [BW-1:0]          m_sel;
  logic [INDEX_BITS-1:0]  q;
  logic [DW-1:0]          qb_lo;
  logic [DW-1:0]          dig;
  logic [NUMW-1:0]        num_nxt;
  logic [NUMW-1:0]        den_nxt;
  logic [NUMW:0]          rem_sh;
  logic [NUMW:0]          rem_diff;
  logic                   rem_ge;
  logic [NUMW-1:0]        rem_nxt;
  logic [FRACTION_BITS-1:0] frac_nxt;
  logic [CW-1:0]          lo_sel;
  logic [CW-1:0]          hi_sel;
  logic [CW:0]            span;
  logic [CW:0]            span_neg;
  logic [CW-1:0]          hi_part;
  logic                   low_nz;
  logic [CW-1:0]          pos_nxt;

  hbs_mul #(
    .AW (AW),
    .BW (BW)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // digit split: q = idx / base via reciprocal, digit from low bits
  always_comb begin
    m_sel   = M_X;
    q       = '0;
    qb_lo   = '0;
    num_nxt = '0;
    den_nxt = '0;
    lo_sel  = box_min[hbs_pkg::AXIS_X];
    hi_sel  = box_max[hbs_pkg::AXIS_X];
    case (axis_r)
      hbs_pkg::AXIS_X: begin
        m_sel   = M_X;
        q       = INDEX_BITS'(prod >> S_X);
        qb_lo   = DW'(DW'(q) * DW'(BASE_X));
        den_nxt = NUMW'(den_r * NUMW'(BASE_X));
        num_nxt = NUMW'(num_r * NUMW'(BASE_X));
        lo_sel  = box_min[hbs_pkg::AXIS_X];
        hi_sel  = box_max[hbs_pkg::AXIS_X];
      end
      hbs_pkg::AXIS_Y: begin
        m_sel   = M_Y;
        q       = INDEX_BITS'(prod >> S_Y);
        qb_lo   = DW'(DW'(q) * DW'(BASE_Y));
        den_nxt = NUMW'(den_r * NUMW'(BASE_Y));
        num_nxt = NUMW'(num_r * NUMW'(BASE_Y));
        lo_sel  = box_min[hbs_pkg::AXIS_Y];
        hi_sel  = box_max[hbs_pkg::AXIS_Y];
      end
      hbs_pkg::AXIS_Z: begin
        m_sel   = M_Z;
        q       = INDEX_BITS'(prod >> S_Z);
        qb_lo   = DW'(DW'(q) * DW'(BASE_Z));
        den_nxt = NUMW'(den_r * NUMW'(BASE_Z));
        num_nxt = NUMW'(num_r * NUMW'(BASE_Z));
        lo_sel  = box_min[hbs_pkg::AXIS_Z];
        hi_sel  = box_max[hbs_pkg::AXIS_Z];
      end
      default: begin
      end
    endcase
    dig = DW'(idx_r) - qb_lo;
  end

  assign mul_a = (state_r == S_MULQ) ? AW'(idx_r) : AW'(spanmag_r);
  assign mul_b = (state_r == S_MULQ) ? m_sel : BW'(frac_r);

  // restoring division step
  assign rem_sh   = {rem_r, 1'b0};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign rem_ge   = (rem_sh >= {1'b0, den_r});
  assign rem_nxt  = rem_ge ? rem_diff[NUMW-1:0] : rem_sh[NUMW-1:0];
  assign frac_nxt = {frac_r[FRACTION_BITS-2:0], rem_ge};

  assign span     = {hi_sel[CW-1], hi_sel} - {lo_sel[CW-1], lo_sel};
  assign span_neg = -span;

  // negative span rounds the offset magnitude up
  assign hi_part = CW'(prod >> FRACTION_BITS);
  assign low_nz  = |prod[FRACTION_BITS-1:0];
  assign pos_nxt = neg_r ? (lo_r - hi_part - CW'(low_nz)) : (lo_r + hi_part);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= hbs_pkg::AXIS_X;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            idx_in_r <= index;
            axis_r   <= hbs_pkg::AXIS_X;
            state_r  <= S_START;
          end
        end
        S_START: begin
          lo_r      <= lo_sel;
          neg_r     <= span[CW];
          spanmag_r <= span[CW] ? span_neg[CW-1:0] : span[CW-1:0];
          idx_r     <= idx_in_r;
          num_r     <= '0;
          den_r     <= NUMW'(1);
          rem_r     <= '0;
          cnt_r     <= CNTW'(FRACTION_BITS);
          state_r   <= (idx_in_r == '0) ? S_DIV : S_MULQ;
        end
        S_MULQ: begin
          state_r <= S_DIGIT;
        end
        S_DIGIT: begin
          num_r <= num_nxt + NUMW'(dig);
          den_r <= den_nxt;
          idx_r <= q;
          rem_r <= num_nxt + NUMW'(dig);
          state_r <= (q == '0) ? S_DIV : S_MULQ;
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          frac_r <= frac_nxt;
          cnt_r  <= cnt_r - CNTW'(1);
          if (cnt_r == CNTW'(1)) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          case (axis_r)
            hbs_pkg::AXIS_X: begin
              pos_r[hbs_pkg::AXIS_X] <= pos_nxt;
              axis_r  <= hbs_pkg::AXIS_Y;
              state_r <= S_START;
            end
            hbs_pkg::AXIS_Y: begin
              pos_r[hbs_pkg::AXIS_Y] <= pos_nxt;
              axis_r  <= hbs_pkg::AXIS_Z;
              state_r <= S_START;
            end
            default: begin
              pos_r[hbs_pkg::AXIS_Z] <= pos_nxt;
              state_r <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_pos   = pos_r;

endmodule

`default_nettype wire

FILE: dv/hbs_point_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hbs_point_checker: point scoreboard for the Halton box sampler
// Mirrors the box registers from the config channel, predicts the point for
// every accepted sample index and compares each result beat, field by field,
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module hbs_point_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic signed [hbs_pkg::COORD_W-1:0]    cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [hbs_pkg::DEF_INDEX_BITS-1:0]    in_sample_index,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [hbs_pkg::COORD_W-1:0]    out_pos_x,
  input  logic signed [hbs_pkg::COORD_W-1:0]    out_pos_y,
  input  logic signed [hbs_pkg::COORD_W-1:0]    out_pos_z,
  output int                                    fail_count,
  output int                                    pending
);
  import hbs_pkg::*;

  localparam int INDEX_W     = DEF_INDEX_BITS;
  localparam int FRAC_W      = DEF_FRACTION_BITS;
  localparam int MAX_REPORTS = 10;
  localparam longint unsigned ROUND_UP = (64'd1 << FRAC_W) - 64'd1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  coord_t box_lo [NUM_AXES];
  coord_t box_hi [NUM_AXES];
  point_t expected_points [$];

  // floor(phi_base(index) * 2^FRAC_W), digit reversal then exact long division
  function automatic logic [FRAC_W-1:0] radical_fraction(input logic [INDEX_W-1:0] index,
                                                         input int unsigned base);
    longint unsigned rest;
    longint unsigned reversed;
    longint unsigned weight;
    longint unsigned remainder;
    logic [FRAC_W-1:0] fraction;
    rest     = index;
    reversed = 0;
    weight   = 1;
    fraction = '0;
    while (rest != 0) begin
      reversed = reversed * base + rest % base;
      weight   = weight * base;
      rest     = rest / base;
    end
    remainder = reversed;
    for (int b = 0; b < FRAC_W; b++) begin
      remainder = remainder << 1;
      fraction  = fraction << 1;
      if (remainder >= weight) begin
        remainder   = remainder - weight;
        fraction[0] = 1'b1;
      end
    end
    return fraction;
  endfunction

  // lo + floor(frac * (hi - lo) / 2^FRAC_W), floor toward minus infinity
  function automatic coord_t place_on_axis(input coord_t lo, input coord_t hi,
                                           input logic [FRAC_W-1:0] frac);
    longint span;
    longint offset;
    longint unsigned product;
    span = longint'(hi) - longint'(lo);
    if (span >= 0) begin
      product = longint'(span) * frac;
      offset  = longint'(product >> FRAC_W);
    end else begin
      product = longint'(-span) * frac;
      offset  = -longint'((product + ROUND_UP) >> FRAC_W);
    end
    return coord_t'(longint'(lo) + offset);
  endfunction

  function automatic point_t predict_point(input logic [INDEX_W-1:0] index);
    point_t p;
    p.x = place_on_axis(box_lo[AXIS_X], box_hi[AXIS_X], radical_fraction(index, DEF_BASE_X));
    p.y = place_on_axis(box_lo[AXIS_Y], box_hi[AXIS_Y], radical_fraction(index, DEF_BASE_Y));
    p.z = place_on_axis(box_lo[AXIS_Z], box_hi[AXIS_Z], radical_fraction(index, DEF_BASE_Z));
    return p;
  endfunction

  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_lo[a] = '0;
        box_hi[a] = '0;
      end
      expected_points.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_X: box_lo[AXIS_X] = cfg_data;
          CFG_MIN_Y: box_lo[AXIS_Y] = cfg_data;
          CFG_MIN_Z: box_lo[AXIS_Z] = cfg_data;
          CFG_MAX_X: box_hi[AXIS_X] = cfg_data;
          CFG_MAX_Y: box_hi[AXIS_Y] = cfg_data;
          CFG_MAX_Z: box_hi[AXIS_Z] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_points.insert(expected_points.size(), predict_point(in_sample_index));
      end
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: unexpected result beat x=%0d y=%0d z=%0d",
                     $time, out_pos_x, out_pos_y, out_pos_z);
          end
        end else begin
          want = expected_points.pop_front();
          if (want.x !== out_pos_x || want.y !== out_pos_y || want.z !== out_pos_z) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("%0t: point mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                       $time, want.x, want.y, want.z, out_pos_x, out_pos_y, out_pos_z);
            end
          end
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top level for the Halton box sampler
// Drives box register writes and sample indices with random gaps and output
// stalls, including a long output hold-off, over a series of box settings;
// the point checker does the prediction and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import hbs_pkg::*;

  localparam int INDEX_W          = DEF_INDEX_BITS;
  localparam int unsigned INDEX_MAX = (32'd1 << INDEX_W) - 32'd1;
  localparam int COORD_SPAN       = 1 << COORD_W;
  localparam int COORD_LOW        = -(1 << (COORD_W - 1));
  localparam int COORD_HIGH       = (1 << (COORD_W - 1)) - 1;
  localparam int RANDOM_PHASES    = 10;
  localparam int ITEMS_PER_PHASE  = 172;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = 200;
  localparam int IDLE_LIMIT       = 5000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum int {
    BOX_SPREAD,
    BOX_INVERTED,
    BOX_EMPTY,
    BOX_FULL,
    BOX_FULL_INVERTED,
    BOX_NARROW
  } box_kind_t;
  localparam int NUM_KINDS = 6;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  coord_t               cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [INDEX_W-1:0]   in_sample_index;
  logic                 out_valid;
  logic                 out_ready;
  coord_t               out_pos_x;
  coord_t               out_pos_y;
  coord_t               out_pos_z;
  int                   fail_count;
  int                   pending;
  int                   hold_requests;
  bit                   steady_feed;

  int unsigned corner_indices [25] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 15, 16, 24, 25, 124, 125, 242, 243,
    390625, 531441, 524288, 699050, 349525, 1048574, 1048575
  };

  halton_box_sampler i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_index (in_sample_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z)
  );

  hbs_point_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_index (in_sample_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic int random_coord();
    int v;
    v = $urandom_range(COORD_SPAN - 1);
    return v + COORD_LOW;
  endfunction

  // full-width indices mostly; small ones, powers of a base and its all-top-digit
  // neighbor, and near-max values exercise the digit loop ends
  function automatic logic [INDEX_W-1:0] random_index();
    int unsigned pick;
    int unsigned base;
    int unsigned power;
    int unsigned steps;
    pick = $urandom_range(9);
    if (pick == 0) return INDEX_W'($urandom_range(63));
    if (pick == 1) begin
      case ($urandom_range(2))
        0: base = DEF_BASE_X;
        1: base = DEF_BASE_Y;
        default: base = DEF_BASE_Z;
      endcase
      power = 1;
      steps = $urandom_range(1, 20);
      repeat (steps) begin
        if (power * base <= INDEX_MAX) power = power * base;
      end
      return INDEX_W'(power - $urandom_range(1));
    end
    if (pick == 2) return INDEX_W'(INDEX_MAX - $urandom_range(15));
    return INDEX_W'($urandom_range(INDEX_MAX));
  endfunction

  // called and returns at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] code, input coord_t value);
    cfg_valid <= 1'b1;
    cfg_index <= code;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_box(input box_kind_t kind);
    int lo [NUM_AXES];
    int hi [NUM_AXES];
    int t;
    int c;
    int start;
    int k;
    logic [CFG_IDX_W-1:0] codes [6];
    coord_t values [6];
    for (int a = 0; a < NUM_AXES; a++) begin
      lo[a] = random_coord();
      hi[a] = random_coord();
      case (kind)
        BOX_SPREAD: begin
          if (lo[a] > hi[a]) begin
            t = lo[a];
            lo[a] = hi[a];
            hi[a] = t;
          end
        end
        BOX_INVERTED: begin
          if (lo[a] < hi[a]) begin
            t = lo[a];
            lo[a] = hi[a];
            hi[a] = t;
          end
        end
        BOX_EMPTY: hi[a] = lo[a];
        BOX_FULL: begin
          lo[a] = COORD_LOW;
          hi[a] = COORD_HIGH;
        end
        BOX_FULL_INVERTED: begin
          lo[a] = COORD_HIGH;
          hi[a] = COORD_LOW;
        end
        default: begin
          c = $urandom_range(COORD_SPAN - 33);
          c = c + COORD_LOW + 16;
          lo[a] = c - $urandom_range(16);
          hi[a] = c + $urandom_range(16);
          if ($urandom_range(1) == 1) begin
            t = lo[a];
            lo[a] = hi[a];
            hi[a] = t;
          end
        end
      endcase
    end
    codes[0] = CFG_MIN_X;  values[0] = coord_t'(lo[AXIS_X]);
    codes[1] = CFG_MIN_Y;  values[1] = coord_t'(lo[AXIS_Y]);
    codes[2] = CFG_MIN_Z;  values[2] = coord_t'(lo[AXIS_Z]);
    codes[3] = CFG_MAX_X;  values[3] = coord_t'(hi[AXIS_X]);
    codes[4] = CFG_MAX_Y;  values[4] = coord_t'(hi[AXIS_Y]);
    codes[5] = CFG_MAX_Z;  values[5] = coord_t'(hi[AXIS_Z]);
    start = $urandom_range(5);
    for (int n = 0; n < 6; n++) begin
      // writes to unmapped indexes must leave the box alone
      if ($urandom_range(3) == 0) begin
        if ($urandom_range(1) == 0) write_reg(CFG_SPARE_A, coord_t'(random_coord()));
        else write_reg(CFG_SPARE_B, coord_t'(random_coord()));
      end
      k = (n + start) % 6;
      write_reg(codes[k], values[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // called and returns at a falling edge; valid stays up between beats sent with no gap
  task automatic send_index(input logic [INDEX_W-1:0] index);
    int gap;
    gap = steady_feed ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_index <= index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // result side: random stalls, calm stretches, and the long hold-off on request
  initial begin
    int stall_left;
    int calm_left;
    int holds_seen;
    stall_left = 0;
    calm_left  = 0;
    holds_seen = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (calm_left != 0) calm_left--;
        else if ($urandom_range(199) == 0) calm_left = $urandom_range(100, 400);
        else if ($urandom_range(3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    box_kind_t kind;
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_sample_index = '0;
    hold_requests   = 0;
    steady_feed     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // box still at reset value
    send_index('0);
    send_index(INDEX_W'(INDEX_MAX));
    repeat (2) send_index(random_index());
    finish_phase();

    load_box(BOX_FULL);
    foreach (corner_indices[n]) send_index(INDEX_W'(corner_indices[n]));
    finish_phase();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < NUM_KINDS) kind = box_kind_t'(ph);
      else kind = box_kind_t'($urandom_range(NUM_KINDS - 1));
      load_box(kind);
      steady_feed = (ph % 3 == 1);
      if (ph == 1) hold_requests++;
      repeat (ITEMS_PER_PHASE) send_index(random_index());
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
